/* sv/m3i_pkg.sv */
// ---------------------------------------------------------------------------
// m3i_pkg: shared constants for the 3x3 matrix inverse
// Default widths and the operand selection tables of the nine cofactors.
// ---------------------------------------------------------------------------
`default_nettype none

package m3i_pkg;

	// Default element format: signed Q16.16.
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Elements of one matrix and of one row.
	localparam int NUM_ELEM = 9;
	localparam int ROW_LEN  = 3;

	// Index of one matrix element, row-major.
	typedef logic [3:0] idx_t;

	// Cofactor j of the adjugate is a[P]*a[Q] - a[R]*a[S].
	localparam idx_t COF_P [NUM_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
	localparam idx_t COF_Q [NUM_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
	localparam idx_t COF_R [NUM_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
	localparam idx_t COF_S [NUM_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

endpackage

`default_nettype wire

/* sv/m3i_adj.sv */
// ---------------------------------------------------------------------------
// m3i_adj: adjugate of a 3x3 matrix
// Registers the matrix, forms the eighteen 2x2 products, then the nine exact
// signed cofactor differences. Three pipeline stages.
// ---------------------------------------------------------------------------
`default_nettype none

module m3i_adj
	import m3i_pkg::*;
#(
	parameter int W = DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [W-1:0]   a [NUM_ELEM],
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [W-1:0]   row0 [ROW_LEN],
	output logic signed [2*W:0]   adj [NUM_ELEM]
);

	localparam int PW = 2 * W;
	localparam int AW = 2 * W + 1;

	logic              v_s1, v_s2, v_s3;
	logic              en_s1, en_s2, en_s3;
	logic signed [W-1:0]  a_s1 [NUM_ELEM];
	logic signed [PW-1:0] prod_c [2*NUM_ELEM];
	logic signed [PW-1:0] prod_s2 [2*NUM_ELEM];
	logic signed [W-1:0]  row0_s2 [ROW_LEN];
	logic signed [AW-1:0] adj_c [NUM_ELEM];
	logic signed [AW-1:0] adj_s3 [NUM_ELEM];
	logic signed [W-1:0]  row0_s3 [ROW_LEN];

	// A stage moves when it is empty or the next one moves.
	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// Cofactor products, one multiplier each.
	always_comb begin
		for (int j = 0; j < NUM_ELEM; j++) begin
			prod_c[2*j]   = a_s1[COF_P[j]] * a_s1[COF_Q[j]];
			prod_c[2*j+1] = a_s1[COF_R[j]] * a_s1[COF_S[j]];
		end
	end

	// Cofactor differences, one bit wider than the products.
	always_comb begin
		for (int j = 0; j < NUM_ELEM; j++) begin
			adj_c[j] = AW'(prod_s2[2*j]) - AW'(prod_s2[2*j+1]);
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en_s1) a_s1 <= a;
		if (en_s2) begin
			prod_s2 <= prod_c;
			for (int k = 0; k < ROW_LEN; k++) row0_s2[k] <= a_s1[k];
		end
		if (en_s3) begin
			adj_s3  <= adj_c;
			row0_s3 <= row0_s2;
		end
	end

	assign out_valid = v_s3;
	assign row0      = row0_s3;
	assign adj       = adj_s3;

endmodule

`default_nettype wire

/* sv/m3i_det.sv */
// ---------------------------------------------------------------------------
// m3i_det: determinant by cofactor expansion along row 0
// Splits each wide cofactor into a low and a high half so that no multiplier
// exceeds one element by one half, recombines, then sums. Three stages.
// ---------------------------------------------------------------------------
`default_nettype none

module m3i_det
	import m3i_pkg::*;
#(
	parameter int W = DATA_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [W-1:0]    row0 [ROW_LEN],
	input  logic signed [2*W:0]    adj_in [NUM_ELEM],
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [2*W:0]    adj [NUM_ELEM],
	output logic signed [3*W+2:0]  det
);

	localparam int AW = 2 * W + 1;
	localparam int HW = 2 * W + 1;
	localparam int DW = 3 * W + 3;

	logic              v_s4, v_s5, v_s6;
	logic              en_s4, en_s5, en_s6;
	logic signed [HW-1:0] lo_c [ROW_LEN];
	logic signed [HW-1:0] hi_c [ROW_LEN];
	logic signed [HW-1:0] lo_s4 [ROW_LEN];
	logic signed [HW-1:0] hi_s4 [ROW_LEN];
	logic signed [DW-1:0] full_c [ROW_LEN];
	logic signed [DW-1:0] full_s5 [ROW_LEN];
	logic signed [DW-1:0] det_c;
	logic signed [DW-1:0] det_s6;
	logic signed [AW-1:0] adj_s4 [NUM_ELEM];
	logic signed [AW-1:0] adj_s5 [NUM_ELEM];
	logic signed [AW-1:0] adj_s6 [NUM_ELEM];

	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign in_ready = en_s4;

	// Partial products: the low half of the cofactor is taken as unsigned.
	always_comb begin
		for (int k = 0; k < ROW_LEN; k++) begin
			lo_c[k] = row0[k] * $signed({1'b0, adj_in[ROW_LEN*k][W-1:0]});
			hi_c[k] = row0[k] * $signed(adj_in[ROW_LEN*k][AW-1:W]);
		end
	end

	// Recombine each full product.
	always_comb begin
		for (int k = 0; k < ROW_LEN; k++) begin
			full_c[k] = (DW'(hi_s4[k]) <<< W) + DW'(lo_s4[k]);
		end
	end

	assign det_c = full_s5[0] + full_s5[1] + full_s5[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s4) v_s4 <= in_valid;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			lo_s4  <= lo_c;
			hi_s4  <= hi_c;
			adj_s4 <= adj_in;
		end
		if (en_s5) begin
			full_s5 <= full_c;
			adj_s5  <= adj_s4;
		end
		if (en_s6) begin
			det_s6 <= det_c;
			adj_s6 <= adj_s5;
		end
	end

	assign out_valid = v_s6;
	assign adj       = adj_s6;
	assign det       = det_s6;

endmodule

`default_nettype wire

/* sv/m3i_div.sv */
// ---------------------------------------------------------------------------
// m3i_div: pipelined division of the adjugate by the determinant
// Nine lanes of restoring division, one quotient bit per stage, behind two
// stages that take magnitudes and detect overflow, and one stage that
// applies the sign, saturates and handles a singular matrix.
// ---------------------------------------------------------------------------
`default_nettype none

module m3i_div
	import m3i_pkg::*;
#(
	parameter int W = DATA_WIDTH_DEF,
	parameter int F = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [2*W:0]    adj [NUM_ELEM],
	input  logic signed [3*W+2:0]  det,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [W-1:0]    b [NUM_ELEM],
	output logic signed [W-1:0]    det_out,
	output logic                   singular
);

	localparam int AW   = 2 * W + 1;
	localparam int DW   = 3 * W + 3;
	localparam int NUMW = AW + 2 * F;
	localparam int RW   = DW + 1;
	localparam int CW   = (NUMW > DW) ? NUMW : DW;

	localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

	// Magnitude stage.
	logic              v_s7, en_s7;
	logic [NUMW-1:0]   numm_c [NUM_ELEM];
	logic [NUM_ELEM-1:0] neg_c;
	logic [DW-1:0]     detmag_c;
	logic signed [DW-1:0] detsh_c;
	logic              detfit_c;
	logic [W-1:0]      detout_c;
	logic [NUMW-1:0]   numm_s7 [NUM_ELEM];
	logic [NUM_ELEM-1:0] neg_s7;
	logic [DW-1:0]     detmag_s7;
	logic              sing_s7;
	logic [W-1:0]      detout_s7;

	// Division stages: index 0 holds the initial remainder, index k+1 the
	// state after quotient bit k.
	logic              v_d [W+1];
	logic              en_d [W+1];
	logic [RW-1:0]     rem_d [W+1][NUM_ELEM];
	logic [W-1:0]      low_d [W+1][NUM_ELEM];
	logic [W-1:0]      q_d [W+1][NUM_ELEM];
	logic [NUM_ELEM-1:0] ovf_d [W+1];
	logic [NUM_ELEM-1:0] neg_d [W+1];
	logic [DW-1:0]     detmag_d [W+1];
	logic              sing_d [W+1];
	logic [W-1:0]      detout_d [W+1];

	logic [NUMW-1:0]   hi_c [NUM_ELEM];
	logic [NUM_ELEM-1:0] ovf_c;
	logic [RW-1:0]     trial_c [W][NUM_ELEM];
	logic              ge_c [W][NUM_ELEM];

	// Output stage.
	logic              v_sf, en_sf;
	logic [W-1:0]      b_c [NUM_ELEM];
	logic [W-1:0]      b_sf [NUM_ELEM];
	logic [W-1:0]      det_sf;
	logic              sing_sf;

	// Enable chain from the output back to the input.
	assign en_sf   = !v_sf || out_ready;
	assign en_d[W] = !v_d[W] || en_sf;
	for (genvar k = 0; k < W; k++) begin : g_en
		assign en_d[k] = !v_d[k] || en_d[k+1];
	end
	assign en_s7    = !v_s7 || en_d[0];
	assign in_ready = en_s7;

	// Magnitudes, quotient signs and the saturated determinant.
	always_comb begin
		for (int i = 0; i < NUM_ELEM; i++) begin
			numm_c[i] = NUMW'(adj[i][AW-1] ? AW'(-adj[i]) : AW'(adj[i])) << (2 * F);
			neg_c[i]  = adj[i][AW-1] ^ det[DW-1];
		end
		detmag_c = det[DW-1] ? DW'(-det) : DW'(det);
		detsh_c  = det >>> (2 * F);
		detfit_c = (&detsh_c[DW-1:W-1]) || !(|detsh_c[DW-1:W-1]);
		detout_c = detfit_c ? detsh_c[W-1:0] : (det[DW-1] ? SAT_MIN : SAT_MAX);
	end

	// Initial remainder; the quotient overflows when it is not below the divisor.
	always_comb begin
		for (int i = 0; i < NUM_ELEM; i++) begin
			hi_c[i]  = numm_s7[i] >> W;
			ovf_c[i] = CW'(hi_c[i]) >= CW'(detmag_s7);
		end
	end

	// One restoring step per stage and lane.
	always_comb begin
		for (int k = 0; k < W; k++) begin
			for (int i = 0; i < NUM_ELEM; i++) begin
				trial_c[k][i] = {rem_d[k][i][RW-2:0], low_d[k][i][W-1]};
				ge_c[k][i]    = trial_c[k][i] >= RW'(detmag_d[k]);
			end
		end
	end

	// Sign, saturation and the singular case.
	always_comb begin
		for (int i = 0; i < NUM_ELEM; i++) begin
			if (sing_d[W]) begin
				b_c[i] = '0;
			end else if (ovf_d[W][i]) begin
				b_c[i] = neg_d[W][i] ? SAT_MIN : SAT_MAX;
			end else if (neg_d[W][i]) begin
				b_c[i] = q_d[W][i][W-1] ? SAT_MIN : W'(-q_d[W][i]);
			end else begin
				b_c[i] = q_d[W][i][W-1] ? SAT_MAX : q_d[W][i];
			end
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_sf <= 1'b0;
			for (int k = 0; k <= W; k++) v_d[k] <= 1'b0;
		end else begin
			if (en_s7) v_s7 <= in_valid;
			if (en_d[0]) v_d[0] <= v_s7;
			for (int k = 0; k < W; k++) begin
				if (en_d[k+1]) v_d[k+1] <= v_d[k];
			end
			if (en_sf) v_sf <= v_d[W];
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (en_s7) begin
			numm_s7   <= numm_c;
			neg_s7    <= neg_c;
			detmag_s7 <= detmag_c;
			sing_s7   <= (det == '0);
			detout_s7 <= detout_c;
		end
		if (en_d[0]) begin
			for (int i = 0; i < NUM_ELEM; i++) begin
				rem_d[0][i] <= RW'(hi_c[i]);
				low_d[0][i] <= numm_s7[i][W-1:0];
				q_d[0][i]   <= '0;
			end
			ovf_d[0]    <= ovf_c;
			neg_d[0]    <= neg_s7;
			detmag_d[0] <= detmag_s7;
			sing_d[0]   <= sing_s7;
			detout_d[0] <= detout_s7;
		end
		for (int k = 0; k < W; k++) begin
			if (en_d[k+1]) begin
				for (int i = 0; i < NUM_ELEM; i++) begin
					rem_d[k+1][i] <= ge_c[k][i] ? (trial_c[k][i] - RW'(detmag_d[k]))
						: trial_c[k][i];
					low_d[k+1][i] <= {low_d[k][i][W-2:0], 1'b0};
					q_d[k+1][i]   <= {q_d[k][i][W-2:0], ge_c[k][i]};
				end
				ovf_d[k+1]    <= ovf_d[k];
				neg_d[k+1]    <= neg_d[k];
				detmag_d[k+1] <= detmag_d[k];
				sing_d[k+1]   <= sing_d[k];
				detout_d[k+1] <= detout_d[k];
			end
		end
		if (en_sf) begin
			b_sf    <= b_c;
			det_sf  <= sing_d[W] ? '0 : detout_d[W];
			sing_sf <= sing_d[W];
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_ELEM; i++) b[i] = b_sf[i];
	end
	assign det_out   = det_sf;
	assign singular  = sing_sf;
	assign out_valid = v_sf;

endmodule

`default_nettype wire

/* sv/matrix3x3_inverse.sv */
// ---------------------------------------------------------------------------
// matrix3x3_inverse: streaming inverse of a 3x3 fixed-point matrix
// Adjugate, determinant and nine pipelined divisions.
// ---------------------------------------------------------------------------
// The block takes one matrix per transaction and can accept a new one in
// every cycle while the output is not held off by m_tready. Three stages
// form the adjugate, three the determinant, then two stages prepare the
// division, the restoring divider spends one stage on each quotient bit,
// and one stage saturates. Each stage advances when it is empty or the
// stage after it advances, so bubbles close up and the input stays open
// while a finished result waits, until every stage holds a transaction.
// The determinant output is the exact determinant floored to FRAC_BITS
// fraction bits and saturated; when it is exactly zero, singular is set
// and all outputs are zero.
`default_nettype none

module matrix3x3_inverse
	import m3i_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// a00, a01, a02, a10, a11, a12, a20, a21, a22, zero fill
	input  logic [(NUM_ELEM*DATA_WIDTH+7)/8*8-1:0] s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// b00, b01, b02, b10, b11, b12, b20, b21, b22, determinant, zero fill
	output logic [((NUM_ELEM+1)*DATA_WIDTH+7)/8*8-1:0] m_tdata,
	// singular
	output logic                               m_tuser
);

	localparam int W    = DATA_WIDTH;
	localparam int INW  = (NUM_ELEM * DATA_WIDTH + 7) / 8 * 8;
	localparam int OUTW = ((NUM_ELEM + 1) * DATA_WIDTH + 7) / 8 * 8;

	logic signed [W-1:0]     a [NUM_ELEM];
	logic                    adj_valid, adj_ready;
	logic signed [W-1:0]     row0 [ROW_LEN];
	logic signed [2*W:0]     adj_a [NUM_ELEM];
	logic                    det_valid, det_ready;
	logic signed [2*W:0]     adj_d [NUM_ELEM];
	logic signed [3*W+2:0]   det;
	logic signed [W-1:0]     b [NUM_ELEM];
	logic signed [W-1:0]     det_out;
	logic [OUTW-1:0]         out_word;

	// Unpack the input elements.
	always_comb begin
		for (int i = 0; i < NUM_ELEM; i++) a[i] = s_tdata[i*W +: W];
	end

	m3i_adj #(.W(W)) u_adj (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.a         (a),
		.out_valid (adj_valid),
		.out_ready (adj_ready),
		.row0      (row0),
		.adj       (adj_a)
	);

	m3i_det #(.W(W)) u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (adj_valid),
		.in_ready  (adj_ready),
		.row0      (row0),
		.adj_in    (adj_a),
		.out_valid (det_valid),
		.out_ready (det_ready),
		.adj       (adj_d),
		.det       (det)
	);

	m3i_div #(.W(W), .F(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (det_valid),
		.in_ready  (det_ready),
		.adj       (adj_d),
		.det       (det),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.b         (b),
		.det_out   (det_out),
		.singular  (m_tuser)
	);

	// Pack the result fields.
	always_comb begin
		out_word = '0;
		for (int i = 0; i < NUM_ELEM; i++) out_word[i*W +: W] = b[i];
		out_word[NUM_ELEM*W +: W] = det_out;
	end
	assign m_tdata = out_word;

	// Input fill bits are ignored.
	logic unused_fill;
	assign unused_fill = ^s_tdata[INW-1:0];

endmodule

`default_nettype wire

/* tb/sv/matrix3x3_inverse_tb.sv */
// ---------------------------------------------------------------------------
// matrix3x3_inverse_tb: self-checking testbench for the 3x3 matrix inverse
// Streams matrices through the block under several idling patterns. Every
// result is compared with an exact wide-integer model of the adjugate,
// determinant and saturated quotients.
// ---------------------------------------------------------------------------
`default_nettype none

module matrix3x3_inverse_tb;
	import m3i_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW        = DATA_WIDTH_DEF;
	localparam int FB        = FRAC_BITS_DEF;
	localparam int IN_W      = (NUM_ELEM * DW + 7) / 8 * 8;
	localparam int OUT_W     = ((NUM_ELEM + 1) * DW + 7) / 8 * 8;
	localparam int LATENCY   = DW + 10;
	localparam int CYCLE_CAP = 2000000;
	localparam int HOLD_LEN  = 400;
	localparam int RAND_ITEMS = 1440;

	localparam logic signed [255:0] SAT_HI = 256'sd2147483647;
	localparam logic signed [255:0] SAT_LO = -256'sd2147483648;

	typedef logic [NUM_ELEM-1:0][DW-1:0] matrix_t;

	// Nine inverse elements plus the determinant, and the singular flag.
	typedef struct packed {
		logic [NUM_ELEM:0][DW-1:0] val;
		logic                      sing;
	} inverse_t;

	typedef struct {
		matrix_t  m;
		bit       typed;
		inverse_t res;
	} vector_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tuser;

	inverse_t expected_q [$];
	inverse_t typed_q [$];
	bit       typed_flag_q [$];
	int       send_idle_pct;
	int       recv_stall_pct;
	bit       hold_req;
	int       mismatches;
	int       results_seen;
	int       singular_seen;
	int       cycles;

	matrix3x3_inverse i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #1 clk = ~clk;

	// Clamp an exact value to the signed output range.
	function automatic logic [DW-1:0] clamp_q16(input logic signed [255:0] v);
		if (v > SAT_HI) begin
			return SAT_HI[DW-1:0];
		end else if (v < SAT_LO) begin
			return SAT_LO[DW-1:0];
		end
		return v[DW-1:0];
	endfunction

	// Exact inverse by the adjugate with wide integer arithmetic.
	function automatic inverse_t invert_exact(input matrix_t m);
		logic signed [255:0] e [NUM_ELEM];
		logic signed [255:0] adj [NUM_ELEM];
		logic signed [255:0] det;
		inverse_t r;
		for (int i = 0; i < NUM_ELEM; i++) begin
			e[i] = {{(256-DW){m[i][DW-1]}}, m[i]};
		end
		for (int j = 0; j < NUM_ELEM; j++) begin
			adj[j] = e[COF_P[j]] * e[COF_Q[j]] - e[COF_R[j]] * e[COF_S[j]];
		end
		det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
		r = '0;
		if (det == 0) begin
			r.sing = 1'b1;
			return r;
		end
		for (int j = 0; j < NUM_ELEM; j++) begin
			r.val[j] = clamp_q16((adj[j] <<< (2 * FB)) / det);
		end
		r.val[NUM_ELEM] = clamp_q16(det >>> (2 * FB));
		return r;
	endfunction

	function automatic matrix_t diag(input logic [DW-1:0] x, y, z);
		matrix_t m;
		m = '0;
		m[0] = x;
		m[4] = y;
		m[8] = z;
		return m;
	endfunction

	function automatic inverse_t diag_res(input logic [DW-1:0] x, y, z, d, input bit s);
		inverse_t r;
		r = '0;
		r.val[0] = x;
		r.val[4] = y;
		r.val[8] = z;
		r.val[NUM_ELEM] = d;
		r.sing = s;
		return r;
	endfunction

	// Random matrix: wide random values, values near full scale, small values, or a singular shape.
	function automatic matrix_t random_matrix();
		matrix_t m;
		int kind;
		kind = $urandom_range(9);
		for (int i = 0; i < NUM_ELEM; i++) begin
			case (kind)
				0, 1: m[i] = $urandom;
				2: m[i] = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
					: 32'h8000_0000 + $urandom_range(3);
				3: m[i] = $signed($urandom_range(15)) - 8;
				default: m[i] = {{13{$urandom_range(1) == 1}}, 19'($urandom)};
			endcase
		end
		if (kind == 8) begin
			// Repeated row.
			for (int c = 0; c < ROW_LEN; c++) begin
				m[6 + c] = m[c];
			end
		end else if (kind == 9 && $urandom_range(1)) begin
			// Zero column.
			for (int r = 0; r < ROW_LEN; r++) begin
				m[r * ROW_LEN + 1] = '0;
			end
		end
		return m;
	endfunction

	// Offer one matrix, with random idle cycles ahead of it.
	task automatic send_matrix(input matrix_t m);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= m;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic drain();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_LEN;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Record predictions of accepted inputs and check each result transaction.
	always @(posedge clk) begin
		inverse_t got, want, typed_res;
		bit typed;
		if (arst_n && s_tvalid && s_tready) begin
			expected_q.push_back(invert_exact(s_tdata[NUM_ELEM*DW-1:0]));
		end
		if (arst_n && m_tvalid && m_tready) begin
			got.val = m_tdata[(NUM_ELEM+1)*DW-1:0];
			got.sing = m_tuser;
			results_seen++;
			if (got.sing) begin
				singular_seen++;
			end
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: result with nothing expected: %h", got);
				end
			end else begin
				want = expected_q.pop_front();
				typed = 1'b0;
				if (typed_flag_q.size() != 0) begin
					typed = typed_flag_q.pop_front();
					typed_res = typed_q.pop_front();
				end
				if (typed && typed_res != want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR: table row %h disagrees with prediction %h",
							typed_res, want);
					end
				end
				for (int f = 0; f <= NUM_ELEM; f++) begin
					if (got.val[f] !== want.val[f]) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("ERROR: result %0d field %0d expected %h got %h",
								results_seen, f, want.val[f], got.val[f]);
						end
					end
				end
				if (got.sing !== want.sing) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("ERROR: result %0d singular expected %b got %b",
							results_seen, want.sing, got.sing);
					end
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		vector_t tbl [$];
		vector_t v;
		int phase_idle [4];
		int phase_stall [4];
		phase_idle  = '{0, 79, 0, 35};
		phase_stall = '{0, 0, 79, 35};
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		mismatches = 0;
		results_seen = 0;
		singular_seen = 0;
		cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; typed results only where they are obvious.
		v.typed = 1'b1;
		v.m = diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		v.res = diag_res(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0);
		tbl.push_back(v);
		v.m = '0;
		v.res = '0;
		v.res.sing = 1'b1;
		tbl.push_back(v);
		v.m = {NUM_ELEM{32'h7FFF_FFFF}};
		tbl.push_back(v);
		v.m = {NUM_ELEM{32'h8000_0000}};
		tbl.push_back(v);
		v.m = diag(32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
		v.res = diag_res(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0008_0000, 0);
		tbl.push_back(v);
		v.m = diag(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
		v.res = diag_res(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 0);
		tbl.push_back(v);
		// Tiny determinants: output reads as zero or minus one LSB.
		v.m = diag(32'h1, 32'h1, 32'h1);
		v.res = diag_res(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 0);
		tbl.push_back(v);
		v.m = diag(32'hFFFF_FFFF, 32'h1, 32'h1);
		v.res = diag_res(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
		tbl.push_back(v);
		v.typed = 1'b0;
		v.m = diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		tbl.push_back(v);
		v.m = diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		tbl.push_back(v);
		v.m = diag(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
		tbl.push_back(v);
		v.m = {32'h0001_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000,
			32'h0, 32'h0001_0000, 32'h0};
		tbl.push_back(v);
		v.m = {32'h0003_0000, 32'hFFFE_0000, 32'h0001_8000, 32'h0000_4000, 32'h0005_0000,
			32'hFFFF_C000, 32'h0002_0000, 32'h0000_0001, 32'hFFFD_0000};
		tbl.push_back(v);
		v.m = {32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5556, 32'hAAAA_AAAA};
		tbl.push_back(v);

		foreach (tbl[i]) begin
			typed_flag_q.push_back(tbl[i].typed);
			typed_q.push_back(tbl[i].res);
			send_matrix(tbl[i].m);
		end
		s_tvalid <= 1'b0;
		drain();

		// Random phases under different idling patterns.
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = phase_idle[p];
			recv_stall_pct = phase_stall[p];
			for (int n = 0; n < RAND_ITEMS / 4; n++) begin
				if (p == 0 && n == 40) begin
					hold_req = 1'b1;
				end
				send_matrix(random_matrix());
			end
			s_tvalid <= 1'b0;
			drain();
		end

		$display("Covered %0d result transactions, %0d singular, under four idle patterns",
			results_seen, singular_seen);
		$display("and one long output hold-off that back-pressured the input.");
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("Mismatches: %0d, left waiting: %0d", mismatches, expected_q.size());
			$display("tb: failure");
		end
		$finish;
	end

endmodule

`default_nettype wire
